// ===== rtl/ecam_pkg.sv =====
`default_nettype none
package ecam_pkg;

  // Operation codes carried in the slave tuser field.
  localparam logic [1:0] OP_MOVE = 2'd0;
  localparam logic [1:0] OP_LOOK = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;

  // Move directions.
  localparam logic [1:0] DIR_FORWARD  = 2'd0;
  localparam logic [1:0] DIR_BACKWARD = 2'd1;
  localparam logic [1:0] DIR_LEFT     = 2'd2;
  localparam logic [1:0] DIR_RIGHT    = 2'd3;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MOVE_SPEED  = 3'd0,
    REG_MOUSE_SENS  = 3'd1,
    REG_WORLD_UP_X  = 3'd2,
    REG_WORLD_UP_Y  = 3'd3,
    REG_WORLD_UP_Z  = 3'd4
  } cfg_reg_t;

  // Angles are Q16.16 degrees.
  localparam logic signed [30:0] DEG_FULL    = 31'sd23592960;
  localparam logic signed [30:0] DEG_HALF    = 31'sd11796480;
  localparam logic signed [30:0] DEG_QUARTER = 31'sd5898240;
  localparam logic signed [30:0] PITCH_LIMIT = 31'sd5832704;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;
  localparam logic signed [15:0] UNIT_Q14    = 16'sd16384;

  // Arctangent of 2^-i in Q16.16 degrees.
  function automatic logic signed [25:0] ecam_atan(input logic [3:0] idx);
    logic signed [25:0] val;
    case (idx)
      4'd0:    val = 26'sd2949120;
      4'd1:    val = 26'sd1740967;
      4'd2:    val = 26'sd919879;
      4'd3:    val = 26'sd466945;
      4'd4:    val = 26'sd234379;
      4'd5:    val = 26'sd117304;
      4'd6:    val = 26'sd58666;
      4'd7:    val = 26'sd29335;
      4'd8:    val = 26'sd14668;
      4'd9:    val = 26'sd7334;
      4'd10:   val = 26'sd3667;
      4'd11:   val = 26'sd1833;
      4'd12:   val = 26'sd917;
      4'd13:   val = 26'sd458;
      4'd14:   val = 26'sd229;
      4'd15:   val = 26'sd115;
      default: val = 26'sd0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ecam_cordic.sv =====
`default_nettype none
module ecam_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [24:0] angle,
  output logic               done,
  output logic signed [15:0] sin_q,
  output logic signed [15:0] cos_q
);
  import ecam_pkg::*;

  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [25:0] z;
  logic               neg;
  logic               busy;
  logic [4:0]         cnt;

  logic signed [25:0] z_in;
  logic signed [25:0] z_fold;
  logic               fold;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] x_rnd;
  logic signed [31:0] y_rnd;

  // Results are rounded to Q2.14 and held within one unit.
  function automatic logic signed [15:0] to_unit(input logic signed [31:0] r,
                                                 input logic flip);
    logic signed [15:0] c;
    if (r > 32'sd16384) begin
      c = UNIT_Q14;
    end else if (r < -32'sd16384) begin
      c = -UNIT_Q14;
    end else begin
      c = r[15:0];
    end
    return flip ? -c : c;
  endfunction

  always_comb begin
    z_in = 26'(angle);
    fold = 1'b0;
    z_fold = z_in;
    if (z_in > 26'(DEG_QUARTER)) begin
      z_fold = z_in - 26'(DEG_HALF);
      fold = 1'b1;
    end else if (z_in < -26'(DEG_QUARTER)) begin
      z_fold = z_in + 26'(DEG_HALF);
      fold = 1'b1;
    end
    dx = y >>> cnt[3:0];
    dy = x >>> cnt[3:0];
    x_rnd = (x + 32'sd8192) >>> 14;
    y_rnd = (y + 32'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x <= CORDIC_GAIN;
        y <= '0;
        z <= z_fold;
        neg <= fold;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt == 5'd16) begin
          cos_q <= to_unit(x_rnd, neg);
          sin_q <= to_unit(y_rnd, neg);
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          if (z >= 0) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - ecam_atan(cnt[3:0]);
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + ecam_atan(cnt[3:0]);
          end
          cnt <= cnt + 5'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ecam_sqrt.sv =====
`default_nettype none
module ecam_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);
  import ecam_pkg::*;

  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitv;
  logic        busy;
  logic [63:0] trial;

  assign trial = r + bitv;
  assign root = r[31:0];

  // One result bit per pass of the remainder, one pass a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v <= value;
        r <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        busy <= 1'b1;
      end else if (busy) begin
        if (bitv == '0) begin
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          if (v >= trial) begin
            v <= v - trial;
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          bitv <= bitv >> 2;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ecam_div.sv =====
`default_nettype none
module ecam_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] mag,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [15:0] quo
);
  import ecam_pkg::*;

  logic [45:0] num;
  logic [32:0] rem;
  logic [15:0] low;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] t;

  // Rounded quotient of mag * 2^14 over the divisor.
  assign num = {1'b0, mag, 14'b0} + {15'b0, divisor[31:1]};
  assign t = {rem[31:0], low[15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= {3'b0, num[45:16]};
        low <= num[15:0];
        dvs <= divisor;
        quo <= '0;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt == 5'd16) begin
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          if (t >= {1'b0, dvs}) begin
            rem <= t - {1'b0, dvs};
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= t;
            quo <= {quo[14:0], 1'b0};
          end
          low <= {low[14:0], 1'b0};
          cnt <= cnt + 5'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/euler_camera_orientation_update.sv =====
// Fly camera state keeper: position, yaw, pitch, and the front and right unit vectors.
// Requests arrive on the s_ channel; s_tuser carries the operation (move, look, set).
// Each request yields exactly one response on the m_ channel holding position, front
// vector, yaw and pitch after the step.
// Configuration (speed, mouse sensitivity, world up) is written through cfg_wr_en,
// cfg_index and cfg_wdata; the user must write it only while no request is in flight,
// as the block does not enforce this. Writes take effect at once. A move does one
// speed product, then one multiply and one saturating add per axis on the shared
// multiplier. A set only runs the angle wrap. A look does two 16-step CORDIC passes,
// two 32-step square roots and six 16-step divisions, all on single shared units, plus
// the shared multiplier for products, squares and the cross product.
// Only one request is worked on at a time; s_tready is high only while idle.
// The response sits in an output register, so a new request is accepted while an
// earlier response waits; a finished request waits if the receiver still stalls.
// Reset puts the camera at the origin looking down -z with yaw -90 degrees and loads
// the default configuration.
`default_nettype none
module euler_camera_orientation_update (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // direction, delta_time, x_offset, y_offset, constrain_pitch, new_yaw, new_pitch
  input  logic [103:0] s_tdata,
  // operation
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, pos_z, front_x, front_y, front_z, yaw_deg, pitch_deg
  output logic [199:0] m_tdata
);
  import ecam_pkg::*;

  typedef enum logic [19:0] {
    ST_IDLE    = 20'h00001,
    ST_MV_V    = 20'h00002,
    ST_MV_VCAP = 20'h00004,
    ST_MV_MUL  = 20'h00008,
    ST_MV_ACC  = 20'h00010,
    ST_LK_X    = 20'h00020,
    ST_LK_XCAP = 20'h00040,
    ST_LK_YCAP = 20'h00080,
    ST_WRAP    = 20'h00100,
    ST_CORD_Y  = 20'h00200,
    ST_CORD_P  = 20'h00400,
    ST_FR_MUL  = 20'h00800,
    ST_FR_CAP  = 20'h01000,
    ST_CR_MUL  = 20'h02000,
    ST_CR_CAP  = 20'h04000,
    ST_SQ_MUL  = 20'h08000,
    ST_SQ_CAP  = 20'h10000,
    ST_SQRT    = 20'h20000,
    ST_DIV     = 20'h40000,
    ST_DONE    = 20'h80000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0]        move_speed;
  logic [15:0]        mouse_sens;
  logic signed [15:0] wu [3];

  // Latched request fields.
  logic [1:0]         op;
  logic [1:0]         dir;
  logic [15:0]        delta_time;
  logic signed [15:0] x_offset;
  logic signed [15:0] y_offset;
  logic               constrain_pitch;

  // Camera state.
  logic signed [31:0] pos [3];
  logic signed [24:0] yaw_angle;
  logic signed [24:0] pitch_angle;
  logic signed [15:0] front [3];
  logic signed [15:0] right [3];

  // Working registers.
  logic [31:0]        vel;
  logic signed [30:0] yaw_acc;
  logic signed [30:0] pitch_acc;
  logic signed [15:0] sin_yaw, cos_yaw, sin_pitch, cos_pitch;
  logic signed [31:0] vraw [3];
  logic signed [31:0] tmp;
  logic [63:0]        sq;
  logic [31:0]        len;
  logic [1:0]         k;
  logic [2:0]         j;
  logic               pass;
  logic               launched;

  // Shared multiplier, registered output.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Unit connections.
  logic               cord_start, cord_done;
  logic signed [24:0] cord_angle;
  logic signed [15:0] cord_sin, cord_cos;
  logic               sqrt_start, sqrt_done;
  logic [31:0]        sqrt_root;
  logic               div_start, div_done;
  logic [15:0]        div_quo;
  logic [31:0]        mag_k;

  assign cord_angle = state == ST_CORD_P ? pitch_angle : yaw_angle;
  assign cord_start = (state == ST_CORD_Y || state == ST_CORD_P) && !launched;
  assign sqrt_start = state == ST_SQRT && !launched;
  assign div_start  = state == ST_DIV && !launched && len != '0;
  assign mag_k      = vraw[k] < 0 ? 32'(-vraw[k]) : 32'(vraw[k]);

  ecam_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .angle (cord_angle),
    .done  (cord_done),
    .sin_q (cord_sin),
    .cos_q (cord_cos)
  );

  ecam_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (sq),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  ecam_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .mag     (mag_k[30:0]),
    .divisor (len),
    .done    (div_done),
    .quo     (div_quo)
  );

  assign s_tready = state == ST_IDLE;

  // Combinational helpers for the move, look and normalize steps.
  logic signed [15:0] mv_vec;
  logic signed [65:0] mv_rnd;
  logic signed [33:0] mv_d;
  logic signed [33:0] mv_sum;
  logic signed [31:0] mv_sat;
  logic signed [65:0] lk_rnd;
  logic signed [30:0] lk_delta;
  logic               yaw_hi, yaw_lo, pitch_hi, pitch_lo;
  logic signed [24:0] pitch_final;
  logic [15:0]        q_clamped;
  logic signed [15:0] norm_val;

  always_comb begin
    mv_vec = dir == DIR_FORWARD || dir == DIR_BACKWARD ? front[k] : right[k];
    // Step is rounded at bit 23, which also halves speed times time.
    mv_rnd = prod + 66'sd4194304;
    mv_d = $signed(mv_rnd[56:23]);
    if (dir == DIR_BACKWARD || dir == DIR_LEFT) begin
      mv_sum = 34'(pos[k]) - mv_d;
    end else begin
      mv_sum = 34'(pos[k]) + mv_d;
    end
    if (mv_sum > 34'sd2147483647) begin
      mv_sat = 32'sh7fff_ffff;
    end else if (mv_sum < -34'sd2147483648) begin
      mv_sat = 32'sh8000_0000;
    end else begin
      mv_sat = mv_sum[31:0];
    end

    lk_rnd = prod + 66'sd8;
    lk_delta = $signed(lk_rnd[34:4]);

    yaw_hi   = yaw_acc >= DEG_HALF;
    yaw_lo   = yaw_acc < -DEG_HALF;
    pitch_hi = pitch_acc >= DEG_HALF;
    pitch_lo = pitch_acc < -DEG_HALF;

    pitch_final = pitch_acc[24:0];
    if (op == OP_LOOK && constrain_pitch) begin
      if (pitch_acc > PITCH_LIMIT) begin
        pitch_final = 25'(PITCH_LIMIT);
      end else if (pitch_acc < -PITCH_LIMIT) begin
        pitch_final = 25'(-PITCH_LIMIT);
      end
    end

    q_clamped = div_quo > 16'd16384 ? 16'd16384 : div_quo;
    norm_val = vraw[k] < 0 ? -$signed(q_clamped) : $signed(q_clamped);

    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MV_V: begin
        mul_a = {17'b0, move_speed};
        mul_b = {17'b0, delta_time};
      end
      ST_MV_MUL: begin
        mul_a = 33'(mv_vec);
        mul_b = {1'b0, vel};
      end
      ST_LK_X: begin
        mul_a = 33'(x_offset);
        mul_b = {17'b0, mouse_sens};
      end
      ST_LK_XCAP: begin
        mul_a = 33'(y_offset);
        mul_b = {17'b0, mouse_sens};
      end
      ST_FR_MUL: begin
        case (k)
          2'd0: begin
            mul_a = 33'(cos_yaw);
            mul_b = 33'(cos_pitch);
          end
          2'd1: begin
            mul_a = 33'(sin_pitch);
            mul_b = 33'(UNIT_Q14);
          end
          default: begin
            mul_a = 33'(sin_yaw);
            mul_b = 33'(cos_pitch);
          end
        endcase
      end
      ST_CR_MUL: begin
        // front cross world up, two products per component.
        case (j)
          3'd0: begin
            mul_a = 33'(front[1]);
            mul_b = 33'(wu[2]);
          end
          3'd1: begin
            mul_a = 33'(front[2]);
            mul_b = 33'(wu[1]);
          end
          3'd2: begin
            mul_a = 33'(front[2]);
            mul_b = 33'(wu[0]);
          end
          3'd3: begin
            mul_a = 33'(front[0]);
            mul_b = 33'(wu[2]);
          end
          3'd4: begin
            mul_a = 33'(front[0]);
            mul_b = 33'(wu[1]);
          end
          default: begin
            mul_a = 33'(front[1]);
            mul_b = 33'(wu[0]);
          end
        endcase
      end
      ST_SQ_MUL: begin
        mul_a = {1'b0, mag_k};
        mul_b = {1'b0, mag_k};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      move_speed <= 16'd640;
      mouse_sens <= 16'd6554;
      wu[0] <= '0;
      wu[1] <= UNIT_Q14;
      wu[2] <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MOVE_SPEED: move_speed <= cfg_wdata;
        REG_MOUSE_SENS: mouse_sens <= cfg_wdata;
        REG_WORLD_UP_X: wu[0] <= $signed(cfg_wdata);
        REG_WORLD_UP_Y: wu[1] <= $signed(cfg_wdata);
        REG_WORLD_UP_Z: wu[2] <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      launched <= 1'b0;
      k <= '0;
      j <= '0;
      pass <= 1'b0;
      pos[0] <= '0;
      pos[1] <= '0;
      pos[2] <= '0;
      yaw_angle <= 25'(-DEG_QUARTER);
      pitch_angle <= '0;
      front[0] <= '0;
      front[1] <= '0;
      front[2] <= -UNIT_Q14;
      right[0] <= UNIT_Q14;
      right[1] <= '0;
      right[2] <= '0;
    end else begin
      // In ST_DONE the response register is handled by the state itself.
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op <= s_tuser;
            dir <= s_tdata[1:0];
            delta_time <= s_tdata[17:2];
            x_offset <= $signed(s_tdata[33:18]);
            y_offset <= $signed(s_tdata[49:34]);
            constrain_pitch <= s_tdata[50];
            k <= '0;
            case (s_tuser)
              OP_MOVE: state <= ST_MV_V;
              OP_LOOK: state <= ST_LK_X;
              OP_SET: begin
                yaw_acc <= 31'($signed(s_tdata[75:51]));
                pitch_acc <= 31'($signed(s_tdata[100:76]));
                state <= ST_WRAP;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_MV_V: state <= ST_MV_VCAP;
        ST_MV_VCAP: begin
          vel <= prod[31:0];
          state <= ST_MV_MUL;
        end
        ST_MV_MUL: state <= ST_MV_ACC;
        ST_MV_ACC: begin
          pos[k] <= mv_sat;
          if (k == 2'd2) begin
            state <= ST_DONE;
          end else begin
            k <= k + 2'd1;
            state <= ST_MV_MUL;
          end
        end
        ST_LK_X: state <= ST_LK_XCAP;
        ST_LK_XCAP: begin
          yaw_acc <= 31'(yaw_angle) + lk_delta;
          state <= ST_LK_YCAP;
        end
        ST_LK_YCAP: begin
          pitch_acc <= 31'(pitch_angle) + lk_delta;
          state <= ST_WRAP;
        end
        ST_WRAP: begin
          // One full turn per cycle until both angles lie in [-180, 180).
          if (yaw_hi) begin
            yaw_acc <= yaw_acc - DEG_FULL;
          end else if (yaw_lo) begin
            yaw_acc <= yaw_acc + DEG_FULL;
          end
          if (pitch_hi) begin
            pitch_acc <= pitch_acc - DEG_FULL;
          end else if (pitch_lo) begin
            pitch_acc <= pitch_acc + DEG_FULL;
          end
          if (!yaw_hi && !yaw_lo && !pitch_hi && !pitch_lo) begin
            yaw_angle <= yaw_acc[24:0];
            pitch_angle <= pitch_final;
            state <= op == OP_LOOK ? ST_CORD_Y : ST_DONE;
          end
        end
        ST_CORD_Y: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (cord_done) begin
            launched <= 1'b0;
            sin_yaw <= cord_sin;
            cos_yaw <= cord_cos;
            state <= ST_CORD_P;
          end
        end
        ST_CORD_P: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (cord_done) begin
            launched <= 1'b0;
            sin_pitch <= cord_sin;
            cos_pitch <= cord_cos;
            k <= '0;
            state <= ST_FR_MUL;
          end
        end
        ST_FR_MUL: state <= ST_FR_CAP;
        ST_FR_CAP: begin
          vraw[k] <= prod[31:0];
          if (k == 2'd2) begin
            k <= '0;
            sq <= '0;
            pass <= 1'b0;
            state <= ST_SQ_MUL;
          end else begin
            k <= k + 2'd1;
            state <= ST_FR_MUL;
          end
        end
        ST_CR_MUL: state <= ST_CR_CAP;
        ST_CR_CAP: begin
          if (!j[0]) begin
            tmp <= prod[31:0];
          end else begin
            vraw[j[2:1]] <= tmp - prod[31:0];
          end
          if (j == 3'd5) begin
            k <= '0;
            sq <= '0;
            state <= ST_SQ_MUL;
          end else begin
            j <= j + 3'd1;
            state <= ST_CR_MUL;
          end
        end
        ST_SQ_MUL: state <= ST_SQ_CAP;
        ST_SQ_CAP: begin
          sq <= sq + prod[63:0];
          if (k == 2'd2) begin
            k <= '0;
            state <= ST_SQRT;
          end else begin
            k <= k + 2'd1;
            state <= ST_SQ_MUL;
          end
        end
        ST_SQRT: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (sqrt_done) begin
            launched <= 1'b0;
            len <= sqrt_root;
            k <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          // A zero-length vector normalizes to the zero vector.
          if (len == '0 || (launched && div_done)) begin
            launched <= 1'b0;
            if (pass) begin
              right[k] <= len == '0 ? 16'sd0 : norm_val;
            end else begin
              front[k] <= len == '0 ? 16'sd0 : norm_val;
            end
            if (k == 2'd2) begin
              k <= '0;
              if (pass) begin
                state <= ST_DONE;
              end else begin
                pass <= 1'b1;
                j <= '0;
                state <= ST_CR_MUL;
              end
            end else begin
              k <= k + 2'd1;
            end
          end else if (!launched) begin
            launched <= 1'b1;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {6'b0, pitch_angle, yaw_angle, front[2], front[1], front[0],
                        pos[2], pos[1], pos[0]};
            m_tvalid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Angles always stay wrapped into [-180, 180) degrees.
  a_yaw_wrapped: assert property (@(posedge clk) disable iff (rst)
    yaw_angle >= 25'(-DEG_HALF) && 31'(yaw_angle) < DEG_HALF)
    else $error("yaw left the wrapped range");

  a_pitch_wrapped: assert property (@(posedge clk) disable iff (rst)
    pitch_angle >= 25'(-DEG_HALF) && 31'(pitch_angle) < DEG_HALF)
    else $error("pitch left the wrapped range");

  // A request in work blocks further requests.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in work");

  // Front components never exceed one unit.
  a_front_unit: assert property (@(posedge clk) disable iff (rst)
    front[0] <= UNIT_Q14 && front[0] >= -UNIT_Q14 &&
    front[1] <= UNIT_Q14 && front[1] >= -UNIT_Q14 &&
    front[2] <= UNIT_Q14 && front[2] >= -UNIT_Q14)
    else $error("front vector component out of range");

  // A pending response is only replaced once it has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("pending response was overwritten");

endmodule
`default_nettype wire

// ===== tb/sv/euler_camera_orientation_update_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module euler_camera_orientation_update_tb;
  import ecam_pkg::*;

  // One camera request as the block sees it on the slave channel.
  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         dir;
    logic [15:0]        dt;
    logic signed [15:0] xoff;
    logic signed [15:0] yoff;
    logic               clamp;
    logic signed [24:0] nyaw;
    logic signed [24:0] npitch;
  } cam_req_t;

  // The state reported after each request, laid out as on m_tdata (px lowest).
  typedef struct packed {
    logic signed [24:0] pitch, yaw;
    logic signed [15:0] fz, fy, fx;
    logic signed [31:0] pz, py, px;
  } cam_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [103:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [199:0] m_tdata;

  euler_camera_orientation_update u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Model copy of configuration and camera state.
  logic [15:0] speed_q, sens_q;
  logic signed [15:0] wup[3];
  longint cam_pos[3], cam_front[3], cam_right[3], cam_up[3];
  longint cam_yaw, cam_pitch;

  cam_req_t   pending_reqs[$];
  cam_state_t expected_states[$];
  int fail_count = 0;

  // Idling knobs, in percent, and the long receiver hold-off.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  bit hold_active = 1'b0;
  bit in_taken = 1'b0;

  localparam longint ATAN_TAB[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  // Arithmetic shift is a floor shift on longint.
  function automatic longint rnd_shift(longint x, int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clampl(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint wrap_angle(longint a);
    longint t;
    t = (a + 11796480) % 23592960;
    if (t < 0) t += 23592960;
    return t - 11796480;
  endfunction

  // Sine and cosine in Q2.14 via a folded 16-step CORDIC.
  function automatic void cordic_sincos(input longint ang, output longint s,
                                        output longint c);
    longint z, x, y, dx, dy;
    bit neg;
    z = ang; x = 163008219; y = 0; neg = 0;
    if (z > 5898240) begin
      z -= 11796480; neg = 1;
    end else if (z < -5898240) begin
      z += 11796480; neg = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    c = clampl(rnd_shift(x, 14), -16384, 16384);
    s = clampl(rnd_shift(y, 14), -16384, 16384);
    if (neg) begin
      c = -c; s = -s;
    end
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void unit_scale(input longint v[3], output longint o[3]);
    longint unsigned sq, len, mag, q;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mag = v[i] < 0 ? -v[i] : v[i];
      sq += mag * mag;
    end
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      mag = v[i] < 0 ? -v[i] : v[i];
      q = (len == 0) ? 0 : ((mag << 14) + len / 2) / len;
      if (q > 16384) q = 16384;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // Rebuild front, right and up from the current yaw and pitch.
  function automatic void refresh_basis();
    longint sy, cy, sp, cp, f[3], w[3], r[3];
    cordic_sincos(cam_yaw, sy, cy);
    cordic_sincos(cam_pitch, sp, cp);
    f = '{cy * cp, sp * 16384, sy * cp};
    unit_scale(f, cam_front);
    w = '{wup[0], wup[1], wup[2]};
    cross3(cam_front, w, r);
    unit_scale(r, cam_right);
    cross3(cam_right, cam_front, r);
    unit_scale(r, cam_up);
  endfunction

  task automatic camera_reset();
    speed_q = 640; sens_q = 6554;
    wup = '{0, 16384, 0};
    cam_pos = '{0, 0, 0};
    cam_yaw = -5898240; cam_pitch = 0;
    cam_front = '{0, 0, -16384};
    cam_right = '{16384, 0, 0};
    cam_up = '{0, 16384, 0};
  endtask

  // Advance the camera by one request and return the reported state.
  function automatic cam_state_t camera_step(cam_req_t r);
    cam_state_t st;
    longint v, d, p, dx, dy;
    bit sub;
    case (r.op)
      OP_MOVE: begin
        v = longint'(speed_q) * longint'(r.dt);
        sub = (r.dir == DIR_BACKWARD) || (r.dir == DIR_LEFT);
        for (int i = 0; i < 3; i++) begin
          d = rnd_shift((r.dir == DIR_FORWARD || r.dir == DIR_BACKWARD ?
                         cam_front[i] : cam_right[i]) * v, 23);
          p = sub ? cam_pos[i] - d : cam_pos[i] + d;
          cam_pos[i] = clampl(p, -64'sd2147483648, 64'sd2147483647);
        end
      end
      OP_LOOK: begin
        dx = rnd_shift(longint'(r.xoff) * longint'(sens_q), 4);
        dy = rnd_shift(longint'(r.yoff) * longint'(sens_q), 4);
        cam_yaw = wrap_angle(cam_yaw + dx);
        cam_pitch = wrap_angle(cam_pitch + dy);
        if (r.clamp) cam_pitch = clampl(cam_pitch, -5832704, 5832704);
        refresh_basis();
      end
      OP_SET: begin
        cam_yaw = wrap_angle(longint'(r.nyaw));
        cam_pitch = wrap_angle(longint'(r.npitch));
      end
      default: ;
    endcase
    st.px = 32'(cam_pos[0]); st.py = 32'(cam_pos[1]); st.pz = 32'(cam_pos[2]);
    st.fx = 16'(cam_front[0]); st.fy = 16'(cam_front[1]); st.fz = 16'(cam_front[2]);
    st.yaw = 25'(cam_yaw); st.pitch = 25'(cam_pitch);
    return st;
  endfunction

  // Driver: presents queued requests at the falling edge. Once offered, a request
  // stays up until it is taken, so valid is never dropped mid-handshake.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tuser <= pending_reqs[0].op;
          s_tdata <= {3'b0, pending_reqs[0].npitch, pending_reqs[0].nyaw,
                      pending_reqs[0].clamp, pending_reqs[0].yoff, pending_reqs[0].xoff,
                      pending_reqs[0].dt, pending_reqs[0].dir};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a long hold-off, counted here, takes priority over the random stalls.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_active && hold_cycles < 3000) begin
        hold_cycles <= hold_cycles + 1;
        m_tready <= 1'b0;
      end else begin
        if (!hold_active) hold_cycles <= 0;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // The request accepted at this edge is the one at the head of the queue.
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_states.push_back(camera_step(pending_reqs.pop_front()));
    end
  end

  // Monitor: compare every accepted response with the oldest expectation.
  always @(posedge clk) begin
    cam_state_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[193:0];
      if (expected_states.size() == 0) begin
        $display("%0t: unexpected response %h", $time, m_tdata);
        fail_count++;
      end else begin
        want = expected_states.pop_front();
        if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz) begin
          $display("%0t: position expected %0d %0d %0d actual %0d %0d %0d", $time,
                   want.px, want.py, want.pz, got.px, got.py, got.pz);
          fail_count++;
        end
        if (got.fx !== want.fx || got.fy !== want.fy || got.fz !== want.fz) begin
          $display("%0t: front expected %0d %0d %0d actual %0d %0d %0d", $time,
                   want.fx, want.fy, want.fz, got.fx, got.fy, got.fz);
          fail_count++;
        end
        if (got.yaw !== want.yaw || got.pitch !== want.pitch) begin
          $display("%0t: yaw/pitch expected %0d %0d actual %0d %0d", $time,
                   want.yaw, want.pitch, got.yaw, got.pitch);
          fail_count++;
        end
      end
    end
  end

  // Write one configuration register and mirror it in the model; only called idle.
  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_MOVE_SPEED: speed_q = val;
      REG_MOUSE_SENS: sens_q = val;
      REG_WORLD_UP_X: wup[0] = $signed(val);
      REG_WORLD_UP_Y: wup[1] = $signed(val);
      default:        wup[2] = $signed(val);
    endcase
  endtask

  // Let the queues drain, then allow a look request's worth of latency.
  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_states.size() == 0);
    repeat (400) @(posedge clk);
  endtask

  function automatic cam_req_t rand_req();
    cam_req_t r;
    r.op = $urandom_range(99) < 3 ? 2'd3 : 2'($urandom_range(2));
    r.dir = 2'($urandom_range(3));
    r.dt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
    r.xoff = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(800) - 400);
    r.yoff = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(800) - 400);
    r.clamp = 1'($urandom_range(1));
    r.nyaw = 25'($urandom);
    r.npitch = 25'($urandom);
    return r;
  endfunction

  function automatic cam_req_t mk(logic [1:0] op, logic [1:0] dir, logic [15:0] dt,
                                  logic [15:0] xo, logic [15:0] yo, logic cl,
                                  logic [24:0] ny, logic [24:0] np);
    cam_req_t r;
    r = '{op, dir, dt, xo, yo, cl, ny, np};
    return r;
  endfunction

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
  endtask

  initial begin
    camera_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: every operation, every direction, field extremes, pitch clamp,
    // angle wrap on set and the unknown code.
    pending_reqs.push_back(mk(OP_MOVE, DIR_FORWARD, 16'hFFFF, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_MOVE, DIR_BACKWARD, 16'h8000, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_MOVE, DIR_LEFT, 16'h0000, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_MOVE, DIR_RIGHT, 16'hFFFF, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_LOOK, 0, 0, 16'h7FFF, 16'h7FFF, 1, 0, 0));
    pending_reqs.push_back(mk(OP_LOOK, 0, 0, 16'h8000, 16'h8000, 0, 0, 0));
    pending_reqs.push_back(mk(OP_LOOK, 0, 0, 16'h0000, 16'h0300, 1, 0, 0));
    pending_reqs.push_back(mk(OP_LOOK, 0, 0, 16'h0000, 16'hFD00, 1, 0, 0));
    pending_reqs.push_back(mk(OP_SET, 0, 0, 0, 0, 0, 25'h0FFFFFF, 25'h1000000));
    pending_reqs.push_back(mk(OP_SET, 0, 0, 0, 0, 0, 25'h0B40000, 25'h14C0000));
    pending_reqs.push_back(mk(2'd3, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
                              25'h1FFFFFF, 25'h1FFFFFF));
    pending_reqs.push_back(mk(OP_LOOK, 0, 0, 16'h0001, 16'hFFFF, 0, 0, 0));
    pending_reqs.push_back(mk(OP_MOVE, DIR_FORWARD, 16'hFFFF, 0, 0, 0, 0, 0));
    drain();

    // Straight-up camera with world up along y makes front x up zero.
    write_reg(REG_MOUSE_SENS, 16'hFFFF);
    write_reg(REG_MOVE_SPEED, 16'hFFFF);
    pending_reqs.push_back(mk(OP_SET, 0, 0, 0, 0, 0, 0, 25'h05A0000));
    pending_reqs.push_back(mk(OP_LOOK, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 8; i++)
      pending_reqs.push_back(mk(OP_MOVE, DIR_FORWARD, 16'hFFFF, 0, 0, 0, 0, 0));
    drain();

    // Random phases, each under its own configuration; phases 0 and 4 share an idling mix.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
        4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      write_reg(REG_MOVE_SPEED, ph == 1 ? 16'h0000 : 16'($urandom));
      write_reg(REG_MOUSE_SENS, ph == 2 ? 16'h0000 : 16'($urandom));
      write_reg(REG_WORLD_UP_X, ph == 3 ? 16'h8000 : 16'($urandom_range(32768) - 16384));
      write_reg(REG_WORLD_UP_Y, ph == 4 ? 16'h4000 : 16'($urandom_range(32768) - 16384));
      write_reg(REG_WORLD_UP_Z, ph == 0 ? 16'h0000 : 16'($urandom_range(32768) - 16384));
      if (ph == 2) begin
        // Long receiver hold-off while requests keep coming, so input backs up.
        hold_active = 1'b1;
      end
      push_random(120);
      drain();
      hold_active = 1'b0;
    end
    // Restore a normal setup for a last batch.
    write_reg(REG_MOVE_SPEED, 16'd640);
    write_reg(REG_MOUSE_SENS, 16'd6554);
    write_reg(REG_WORLD_UP_X, 16'h0000);
    write_reg(REG_WORLD_UP_Y, 16'h4000);
    write_reg(REG_WORLD_UP_Z, 16'h0000);
    send_idle_pct = 10; recv_stall_pct = 10;
    push_random(40);
    drain();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Limit: a time-out over all 783 requests plus the hold-off.
  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/ecam_pkg.sv
rtl/ecam_cordic.sv
rtl/ecam_sqrt.sv
rtl/ecam_div.sv
rtl/euler_camera_orientation_update.sv
tb/sv/euler_camera_orientation_update_tb.sv
